@@ hw/rtl/sbda_pkg.sv @@
// Shared types and constants for the signed binary to decimal ASCII converter.
// Used by the controller, the datapath and the top level.
package sbda_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
    localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int unsigned PROD_W     = 2 * VALUE_W;
    localparam int unsigned RECIP_SH   = 35;
    localparam int unsigned QUOT_W     = PROD_W - RECIP_SH;

    // floor(x * RECIP_10 / 2**35) == x / 10 for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0]  DIGIT_BASE = 8'h30;
    localparam logic [CHAR_W-1:0]  MINUS_CODE = 8'h2D;

    typedef struct packed {
        logic load;        // take a new value, reset digit count
        logic mul;         // form reciprocal product
        logic sub;         // store remainder digit, keep quotient
        logic emit_sign;   // load minus sign into output register
        logic emit_digit;  // load next digit into output register
    } t_dp_cmd;

    typedef struct packed {
        logic neg;         // value was negative
        logic q_zero;      // quotient of the current step is zero
        logic out_free;    // output register can take a character
        logic idx_zero;    // next digit to emit is the final one
    } t_dp_status;

endpackage

@@ hw/rtl/sbda_datapath.sv @@
// Datapath: magnitude register, reciprocal divide-by-ten, digit store and
// output register. Depends on sbda_pkg; driven by sbda_ctrl.
module sbda_datapath
    import sbda_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_out_ready,
    output t_dp_status                o_status,
    output logic                      o_out_valid,
    output logic [CHAR_W-1:0]         o_out_char,
    output logic                      o_out_last
);

    logic [VALUE_W-1:0] r_mag;
    logic               r_neg;
    logic [PROD_W-1:0]  r_prod;
    logic [3:0]         r_dig [NUM_DIGITS];
    logic [CNT_W-1:0]   r_ndig;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic [VALUE_W-1:0] w_raw;
    logic [QUOT_W-1:0]  w_quot;
    logic [VALUE_W-1:0] w_rem;
    logic               w_out_free;

    assign w_raw      = i_value;
    assign w_quot     = r_prod[PROD_W-1:RECIP_SH];
    assign w_rem      = r_mag - {w_quot, 3'b000} - {2'b00, w_quot, 1'b0};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.neg      = r_neg;
    assign o_status.q_zero   = (w_quot == '0);
    assign o_status.out_free = w_out_free;
    assign o_status.idx_zero = (r_idx == '0);

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= w_raw[VALUE_W-1];
            r_mag <= w_raw[VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP_10);
        end
        if (i_cmd.sub) begin
            r_dig[r_ndig[IDX_W-1:0]] <= w_rem[3:0];
            r_mag                    <= VALUE_W'(w_quot);
        end
        if (i_cmd.emit_sign) begin
            r_out_char <= MINUS_CODE;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= DIGIT_BASE | {4'b0000, r_dig[r_idx]};
            r_out_last <= (r_idx == '0);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ndig <= '0;
            end else if (i_cmd.sub) begin
                r_ndig <= r_ndig + 1'b1;
                r_idx  <= r_ndig[IDX_W-1:0];
            end else if (i_cmd.emit_digit) begin
                r_idx <= r_idx - 1'b1;
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_ndig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ndig <= CNT_W'(NUM_DIGITS))
        else $error("digit count beyond store depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_sign || i_cmd.emit_digit) |-> w_out_free)
        else $error("character loaded over an untaken one");

    a_digit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |=> (r_out_char >= DIGIT_BASE) &&
                             (r_out_char <= DIGIT_BASE + 8'd9))
        else $error("emitted digit outside 0..9");

endmodule

@@ hw/rtl/sbda_ctrl.sv @@
// Controller state machine: sequences load, divide steps and emission.
// Depends on sbda_pkg; drives sbda_datapath through t_dp_cmd.
module sbda_ctrl
    import sbda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                if (!i_status.q_zero) begin
                    n_state = S_MUL;
                end else if (i_status.neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/signed_binary_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Instantiates sbda_ctrl and sbda_datapath; depends on sbda_pkg.
//
// Usage:
//   Slave stream takes one request per number: s_axis_tdata is the signed
//   32-bit value. Master stream gives its text, one character per beat,
//   most significant first, with a leading '-' for negative values;
//   m_axis_tlast marks the final character. Zero gives a single '0'.
// Timing:
//   Accept, then a reciprocal multiply and a remainder step per decimal
//   digit, up to ten digits. Characters then leave one per cycle through
//   the output register while m_axis_tready is high. The conversion time
//   grows with the digit count and a sign; the shared divide-by-ten
//   multiplier and the single output register set it.
//   s_axis_tready is high only while no number is in conversion; the next
//   request is taken while the final character still waits in the output
//   register.
// Reset: synchronous, active low; clears the state machine and output valid.
// Stall: a low m_axis_tready holds the current character and halts emission.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic signed [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [CHAR_W-1:0]         m_axis_tdata,   // [7:0] character
    output logic                      m_axis_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sbda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    sbda_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

@@ bench/sbda_checker.sv @@
`timescale 1ns / 100ps
// Checker for the signed binary to decimal ASCII converter: watches both streams,
// predicts the text of every accepted number and compares it character by character.
// Depends on sbda_pkg for widths and character codes.
module sbda_checker
    import sbda_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic signed [VALUE_W-1:0] i_in_value,    // [31:0] value
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [CHAR_W-1:0]         i_out_char,    // [7:0] character
    input  logic                      i_out_last,
    output int                        o_pending,
    output int                        o_fail_count,
    output int                        o_char_count
);

    localparam logic [VALUE_W-1:0] RADIX = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    t_text_char text_due[$];
    int         fail_count;
    int         char_count;

    initial begin
        fail_count   = 0;
        char_count   = 0;
    end

    // decimal text of one number, sign first, no leading zeros
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [CHAR_W-1:0]  digit_codes[$];
        magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do begin
            digit_codes.push_front(DIGIT_BASE + CHAR_W'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        if (value[VALUE_W-1])
            text_due.push_back('{code: MINUS_CODE, last: 1'b0});
        foreach (digit_codes[i])
            text_due.push_back('{code: digit_codes[i], last: (i == digit_codes.size() - 1)});
    endfunction

    always @(posedge i_clk) begin
        t_text_char due;
        if (i_rst_n) begin
            // results first: a request taken at this edge cannot have produced one yet
            if (i_out_valid && i_out_ready) begin
                char_count++;
                if (text_due.size() == 0) begin
                    $error("unexpected character 0x%02h (last %0b)", i_out_char, i_out_last);
                    fail_count++;
                end else begin
                    due = text_due.pop_front();
                    if (i_out_char !== due.code) begin
                        $error("character: expected 0x%02h, got 0x%02h", due.code, i_out_char);
                        fail_count++;
                    end
                    if (i_out_last !== due.last) begin
                        $error("last: expected %0b, got %0b", due.last, i_out_last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_text(i_in_value);
        end
        o_pending    <= text_due.size();
        o_fail_count <= fail_count;
        o_char_count <= char_count;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, request stimulus and output back-pressure.
// Instantiates signed_binary_to_decimal_ascii and sbda_checker; depends on sbda_pkg.
module tb_top;
    import sbda_pkg::*;

    localparam int RANDOM_PER_PHASE = 60;
    localparam int SETTLE_CYCLES    = 40;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic signed [VALUE_W-1:0] s_axis_tdata;    // [31:0] value
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [CHAR_W-1:0]         m_axis_tdata;    // [7:0] character
    logic                      m_axis_tlast;

    int pending;
    int fail_count;
    int char_count;
    int send_idle_pct;
    int recv_stall_pct;
    int numbers_sent;
    int negatives_sent;
    int zeros_sent;

    signed_binary_to_decimal_ascii u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sbda_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_value   (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_char   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_char_count (char_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    task automatic send_value(input logic [VALUE_W-1:0] value);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        numbers_sent++;
        if (value[VALUE_W-1])
            negatives_sent++;
        if (value == 0)
            zeros_sent++;
    endtask

    // hold off requests until all outstanding text has left
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // mostly values of a chosen digit count so short texts are common too
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned        pick;
        int unsigned        digits;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] mag;
        logic               negative;
        pick     = $urandom_range(9, 0);
        digits   = $urandom_range(10, 1);
        negative = 1'($urandom_range(1, 0));
        lo = 1;
        repeat (digits - 1) lo = lo * 10;
        if (digits == 10)
            hi = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            hi = lo * 10 - 1;
        if (pick < 3)
            return $urandom();
        if (pick == 3)
            mag = $urandom_range(1, 0) ? lo : hi;
        else
            mag = $urandom_range(hi, lo);
        return negative ? (~mag + 1'b1) : mag;
    endfunction

    initial begin
        logic [VALUE_W-1:0] directed[21] = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd7,
            32'd12345, 32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999,
            32'd1_999_999_999, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'h5555_5555, 32'hAAAA_AAAA, 32'd4_294_967_286, 32'd0
        };
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        numbers_sent   = 0;
        negatives_sent = 0;
        zeros_sent     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_value(directed[i]);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_value(random_value());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Converted %0d numbers (%0d negative, %0d zero) across four flow-control phases.",
                 numbers_sent, negatives_sent, zeros_sent);
        $display("%0d characters compared with predicted decimal text.", char_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sbda_pkg.sv
hw/rtl/sbda_datapath.sv
hw/rtl/sbda_ctrl.sv
hw/rtl/signed_binary_to_decimal_ascii.sv
bench/sbda_checker.sv
bench/tb_top.sv
